// ===== src/dps_pkg.sv =====
// Package: shared types and constants for the dynamic priority scheduler.
package dps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_ADMITTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_ZERO_NEED = 3'd2,
        ST_REQUEUED  = 3'd3,
        ST_FINISHED  = 3'd4,
        ST_IDLE      = 3'd5
    } status_t;

    typedef enum logic {
        KIND_ADMIT = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef enum logic {
        S_READY,
        S_REQUEUE
    } state_t;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] prio;
        logic [15:0]        need;
        logic [15:0]        elapsed;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_cmd_t;

endpackage

// ===== src/dps_cell.sv =====
// One slot of the sorted ready queue: holds an entry, shifts left or right.
module dps_cell
    import dps_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    input  logic      prev_stays,
    input  logic      occupied,
    output entry_t    entry,
    output logic      stays
);

    entry_t entry_reg;
    entry_t entry_next;

    assign stays = occupied && ($signed(entry_reg.prio) >= $signed(cmd.ent.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (!stays)
                begin
                    entry_next = prev_stays ? cmd.ent : left_entry;
                end
            end
            CELL_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/dynamic_priority_scheduler.sv =====
// Top level: ready queue with priority aging built from a chain of cells.
//
//  channel  | handshake                   | fields
//  ---------+-----------------------------+------------------------------------------
//  item     | item_valid / item_stall     | kind, process_id, priority_req, need_time
//  result   | result_valid / result_stall | status, ran_id, ran_priority, ran_elapsed,
//           |                             | queue_count
//
// For an admit word every cell compares and shifts in the same edge.
// A tick word that finishes its process or finds the queue empty stays in S_READY;
// a requeued one pops in S_READY and does the sorted reinsert in S_REQUEUE.
// One result word per item word, held in an output register until taken.
// A stalled result holds item_stall high; reset empties the queue at once.
module dynamic_priority_scheduler
    import dps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               kind,
    input  logic [7:0]         process_id,
    input  logic signed [15:0] priority_req,
    input  logic [15:0]        need_time,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         status,
    output logic [7:0]         ran_id,
    output logic signed [15:0] ran_priority,
    output logic [15:0]        ran_elapsed,
    output logic [4:0]         queue_count
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             hold_reg, hold_next;
    logic               result_valid_reg, result_valid_next;
    status_t            status_reg, status_next;
    logic [7:0]         ran_id_reg, ran_id_next;
    logic signed [15:0] ran_priority_reg, ran_priority_next;
    logic [15:0]        ran_elapsed_reg, ran_elapsed_next;
    logic [CNT_W-1:0]   queue_count_reg, queue_count_next;

    cell_cmd_t          cmd;
    entry_t             cell_q [QUEUE_DEPTH];
    logic               cell_stays [QUEUE_DEPTH];
    logic               out_free;
    logic               accept;
    entry_t             head;
    logic [15:0]        head_el;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   prev_s;
            logic   occ;
            if (gi == 0)
            begin : g_first
                assign left_e = cmd.ent;
                assign prev_s = 1'b1;
            end
            else
            begin : g_rest
                assign left_e = cell_q[gi-1];
                assign prev_s = cell_stays[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = cell_q[gi];
            end
            else
            begin : g_mid
                assign right_e = cell_q[gi+1];
            end
            assign occ = (count_reg > CNT_W'(gi));
            dps_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .left_entry  (left_e),
                .right_entry (right_e),
                .prev_stays  (prev_s),
                .occupied    (occ),
                .entry       (cell_q[gi]),
                .stays       (cell_stays[gi])
            );
        end
    endgenerate

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_READY) || !out_free;
    assign accept     = item_valid && !item_stall;
    assign head       = cell_q[0];
    assign head_el    = head.elapsed + 16'd1;

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign ran_id       = ran_id_reg;
    assign ran_priority = ran_priority_reg;
    assign ran_elapsed  = ran_elapsed_reg;
    assign queue_count  = 5'(queue_count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        hold_next         = hold_reg;
        result_valid_next = result_valid_reg && result_stall;
        status_next       = status_reg;
        ran_id_next       = ran_id_reg;
        ran_priority_next = ran_priority_reg;
        ran_elapsed_next  = ran_elapsed_reg;
        queue_count_next  = queue_count_reg;
        cmd.op            = CELL_HOLD;
        cmd.ent.id        = process_id;
        cmd.ent.prio      = priority_req;
        cmd.ent.need      = need_time;
        cmd.ent.elapsed   = 16'd0;

        unique case (state_reg)
            S_READY:
            begin
                if (accept)
                begin
                    result_valid_next = 1'b1;
                    ran_id_next       = 8'd0;
                    ran_priority_next = 16'sd0;
                    ran_elapsed_next  = 16'd0;
                    queue_count_next  = count_reg;
                    if (kind == KIND_ADMIT)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (need_time == 16'd0)
                        begin
                            status_next = ST_ZERO_NEED;
                        end
                        else
                        begin
                            cmd.op           = CELL_INSERT;
                            status_next      = ST_ADMITTED;
                            count_next       = count_reg + CNT_W'(1);
                            queue_count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.op            = CELL_POP;
                        count_next        = count_reg - CNT_W'(1);
                        ran_id_next       = head.id;
                        ran_priority_next = head.prio;
                        ran_elapsed_next  = head_el;
                        hold_next.id      = head.id;
                        hold_next.need    = head.need;
                        hold_next.elapsed = head_el;
                        hold_next.prio    = (head.prio == 16'sh8000) ? head.prio
                                                                    : head.prio - 16'sd1;
                        if (head_el == head.need)
                        begin
                            status_next      = ST_FINISHED;
                            queue_count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_REQUEUED;
                            state_next  = S_REQUEUE;
                        end
                    end
                end
            end
            S_REQUEUE:
            begin
                cmd.op     = CELL_INSERT;
                cmd.ent    = hold_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_READY;
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_READY;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg         <= hold_next;
        status_reg       <= status_next;
        ran_id_reg       <= ran_id_next;
        ran_priority_reg <= ran_priority_next;
        ran_elapsed_reg  <= ran_elapsed_next;
        queue_count_reg  <= queue_count_next;
    end

endmodule

// ===== src/dps_checker.sv =====
// Checker: port-level properties of the scheduler, bound to the top level.
module dps_checker
    import dps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               kind,
    input logic [7:0]         process_id,
    input logic signed [15:0] priority_req,
    input logic [15:0]        need_time,
    input logic               result_valid,
    input logic               result_stall,
    input logic [2:0]         status,
    input logic [7:0]         ran_id,
    input logic signed [15:0] ran_priority,
    input logic [15:0]        ran_elapsed,
    input logic [4:0]         queue_count
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(kind) && $stable(process_id)
            && $stable(priority_req) && $stable(need_time))
        else $error("stalled item word changed");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(ran_id) && $stable(ran_elapsed) && $stable(queue_count))
        else $error("stalled result word changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> queue_count <= 5'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_ADMITTED || status == ST_FULL
            || status == ST_ZERO_NEED || status == ST_IDLE)
        |-> ran_id == 8'd0 && ran_priority == 16'sd0 && ran_elapsed == 16'd0)
        else $error("run fields set on a word without a run");

    a_ran_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_REQUEUED || status == ST_FINISHED)
        |-> ran_elapsed != 16'd0)
        else $error("run word with zero elapsed time");

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (.*);
